@@ rtl/abra_pkg.sv @@
// ----------------------------------------------------------------------------
// abra_pkg
// Shared types and constants for the alternating-bit receiver with Adler-32.
// ----------------------------------------------------------------------------
package abra_pkg;

	// payload bytes covered by the checksum per packet
	localparam int MAX_PAYLOAD = 512;
	localparam int BCNT_W      = $clog2(MAX_PAYLOAD + 1);

	// queue between front and back end (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [16:0] ADLER_MOD   = 17'd65521;
	localparam logic [3:0]  ATTEMPT_MAX = 4'd15;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_LAST   = 2'd1,
		KIND_RX_ERR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STAT_ACCEPTED  = 3'd0,
		STAT_CSUM_ERR  = 3'd1,
		STAT_WRONG_SEQ = 3'd2,
		STAT_RX_ERR    = 3'd3,
		STAT_GIVEN_UP  = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_PKTS_EXPECTED = 1'b0,
		CFG_RETRY_LIMIT   = 1'b1
	} cfg_idx_t;

	// one classified request as it sits in the queue
	typedef struct packed {
		kind_t       kind;
		logic        use_byte;
		logic [7:0]  data_byte;
		logic        seq;
		logic        ack;
		logic [31:0] checksum;
	} entry_t;

	// result item, ack_valid in the lowest bit
	typedef struct packed {
		logic        session_done;
		logic [15:0] packets_received;
		status_t     status;
		logic        ack_value;
		logic        ack_valid;
	} result_t;

endpackage

@@ rtl/abra_front.sv @@
// ----------------------------------------------------------------------------
// abra_front
// Accepts requests, classifies them and decides per byte whether it enters
// the checksum (zero-byte cutoff and payload length limit).
// ----------------------------------------------------------------------------
module abra_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [abra_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tlast,
	input  logic                             s_tuser,
	input  logic                             q_full,
	output logic                             q_push,
	output abra_pkg::entry_t                 q_entry
);

	logic                       zero_seen_q;
	logic [abra_pkg::BCNT_W-1:0] byte_cnt_q;
	logic [7:0]                 data_byte;
	logic                       in_window;

	assign data_byte = s_tdata[7:0];
	assign s_tready  = !q_full;
	assign q_push    = s_tvalid && !q_full;
	assign in_window = !zero_seen_q
		&& (byte_cnt_q < abra_pkg::BCNT_W'(abra_pkg::MAX_PAYLOAD));

	always_comb begin
		q_entry.data_byte = data_byte;
		q_entry.seq       = s_tdata[8];
		q_entry.ack       = s_tdata[9];
		q_entry.checksum  = s_tdata[41:10];
		q_entry.use_byte  = !s_tuser && in_window && (data_byte != 8'd0);
		if (s_tuser) begin
			q_entry.kind = abra_pkg::KIND_RX_ERR;
		end else if (s_tlast) begin
			q_entry.kind = abra_pkg::KIND_LAST;
		end else begin
			q_entry.kind = abra_pkg::KIND_BYTE;
		end
	end

	// packet-local window; restarts after a last byte or a receive error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_seen_q <= 1'b0;
			byte_cnt_q  <= '0;
		end else if (q_push) begin
			if (s_tuser || s_tlast) begin
				zero_seen_q <= 1'b0;
				byte_cnt_q  <= '0;
			end else if (in_window) begin
				if (data_byte == 8'd0) begin
					zero_seen_q <= 1'b1;
				end else begin
					byte_cnt_q <= byte_cnt_q + abra_pkg::BCNT_W'(1);
				end
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= abra_pkg::BCNT_W'(abra_pkg::MAX_PAYLOAD))
		else $error("byte count past payload limit");

	a_zero_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(zero_seen_q && q_push && !s_tuser && !s_tlast) |=> $stable(byte_cnt_q))
		else $error("byte count moved after zero byte");

	a_no_use_out: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !in_window) |-> !q_entry.use_byte)
		else $error("byte outside window marked for checksum");

endmodule

@@ rtl/abra_queue.sv @@
// ----------------------------------------------------------------------------
// abra_queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
module abra_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  abra_pkg::entry_t  push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output abra_pkg::entry_t  head_entry
);

	abra_pkg::entry_t              mem_q [abra_pkg::QUEUE_DEPTH];
	logic [abra_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [abra_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [abra_pkg::QCNT_W-1:0]  count_q;

	assign full       = (count_q == abra_pkg::QCNT_W'(abra_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + abra_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + abra_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + abra_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - abra_pkg::QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= abra_pkg::QCNT_W'(abra_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

@@ rtl/abra_back.sv @@
// ----------------------------------------------------------------------------
// abra_back
// Runs the Adler-32 update and the alternating-bit session logic, and holds
// the result register toward the output stream.
// ----------------------------------------------------------------------------
module abra_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  abra_pkg::cfg_idx_t                cfg_addr,
	input  logic [15:0]                       cfg_wdata,
	input  logic                              head_valid,
	input  abra_pkg::entry_t                  head_entry,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [abra_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic [15:0] pkts_expected_q;
	logic [3:0]  retry_limit_q;

	logic [15:0] sum_low_q, sum_high_q;
	logic        expected_seq_q, last_good_ack_q, held_seq_q, held_ack_q;
	logic [3:0]  attempt_q;
	logic [15:0] accepted_q;
	logic        finished_q;

	logic             out_valid_q;
	abra_pkg::result_t out_q;

	logic [16:0] low_add, high_add;
	logic [15:0] low_upd, high_upd, low_byte, high_byte;
	logic [15:0] sum_low_d, sum_high_d;
	logic        expected_seq_d, last_good_ack_d, held_seq_d, held_ack_d;
	logic [3:0]  attempt_d, attempt_inc;
	logic [15:0] accepted_d, accepted_inc;
	logic        finished_d;
	logic        judged, good, take;
	abra_pkg::result_t res;

	assign pop      = head_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(abra_pkg::OUT_TDATA_W - $bits(abra_pkg::result_t))'(0), out_q};

	// two modular adds; sums always stay below the modulus
	always_comb begin
		low_add   = {1'b0, sum_low_q} + {9'd0, head_entry.data_byte};
		low_byte  = (low_add >= abra_pkg::ADLER_MOD) ?
			16'(low_add - abra_pkg::ADLER_MOD) : low_add[15:0];
		high_add  = {1'b0, sum_high_q} + {1'b0, low_byte};
		high_byte = (high_add >= abra_pkg::ADLER_MOD) ?
			16'(high_add - abra_pkg::ADLER_MOD) : high_add[15:0];
		low_upd   = head_entry.use_byte ? low_byte : sum_low_q;
		high_upd  = head_entry.use_byte ? high_byte : sum_high_q;
	end

	always_comb begin
		sum_low_d       = sum_low_q;
		sum_high_d      = sum_high_q;
		expected_seq_d  = expected_seq_q;
		last_good_ack_d = last_good_ack_q;
		held_seq_d      = held_seq_q;
		held_ack_d      = held_ack_q;
		attempt_d       = attempt_q;
		accepted_d      = accepted_q;
		finished_d      = finished_q;
		judged          = 1'b0;
		good            = 1'b0;
		take            = 1'b0;
		res.ack_valid   = 1'b0;
		res.ack_value   = 1'b0;
		res.status      = abra_pkg::STAT_ACCEPTED;
		attempt_inc  = (attempt_q != abra_pkg::ATTEMPT_MAX) ? attempt_q + 4'd1 : attempt_q;
		accepted_inc = (accepted_q != abra_pkg::COUNT_MAX) ? accepted_q + 16'd1 : accepted_q;

		if (pop && !finished_q) begin
			case (head_entry.kind)
				abra_pkg::KIND_BYTE: begin
					sum_low_d  = low_upd;
					sum_high_d = high_upd;
				end
				abra_pkg::KIND_LAST: begin
					judged     = 1'b1;
					held_seq_d = head_entry.seq;
					held_ack_d = head_entry.ack;
					sum_low_d  = 16'd1;
					sum_high_d = 16'd0;
					if ({high_upd, low_upd} != head_entry.checksum) begin
						res.status = abra_pkg::STAT_CSUM_ERR;
					end else if (head_entry.seq != expected_seq_q) begin
						res.status    = abra_pkg::STAT_WRONG_SEQ;
						res.ack_valid = 1'b1;
						res.ack_value = last_good_ack_q;
					end else begin
						res.status    = abra_pkg::STAT_ACCEPTED;
						res.ack_valid = 1'b1;
						res.ack_value = head_entry.ack;
						good          = 1'b1;
					end
				end
				default: begin
					judged        = 1'b1;
					sum_low_d     = 16'd1;
					sum_high_d    = 16'd0;
					res.status    = abra_pkg::STAT_RX_ERR;
					res.ack_valid = 1'b1;
					res.ack_value = last_good_ack_q;
				end
			endcase

			if (judged) begin
				attempt_d = attempt_inc;
				take      = good || (attempt_inc >= retry_limit_q);
				if (take) begin
					if (!good) begin
						res.status = abra_pkg::STAT_GIVEN_UP;
					end
					last_good_ack_d = held_ack_d;
					expected_seq_d  = !held_seq_d;
					accepted_d      = accepted_inc;
					attempt_d       = 4'd0;
					if ((attempt_inc >= retry_limit_q) || (accepted_inc >= pkts_expected_q)) begin
						finished_d = 1'b1;
					end
				end
			end
		end
		res.packets_received = accepted_d;
		res.session_done     = finished_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkts_expected_q <= 16'd1;
			retry_limit_q   <= 4'd8;
			sum_low_q       <= 16'd1;
			sum_high_q      <= 16'd0;
			expected_seq_q  <= 1'b0;
			last_good_ack_q <= 1'b0;
			held_seq_q      <= 1'b0;
			held_ack_q      <= 1'b0;
			attempt_q       <= 4'd0;
			accepted_q      <= 16'd0;
			finished_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_addr)
					abra_pkg::CFG_PKTS_EXPECTED: pkts_expected_q <= cfg_wdata;
					abra_pkg::CFG_RETRY_LIMIT:   retry_limit_q   <= cfg_wdata[3:0];
					default: ;
				endcase
			end
			sum_low_q       <= sum_low_d;
			sum_high_q      <= sum_high_d;
			expected_seq_q  <= expected_seq_d;
			last_good_ack_q <= last_good_ack_d;
			held_seq_q      <= held_seq_d;
			held_ack_q      <= held_ack_d;
			attempt_q       <= attempt_d;
			accepted_q      <= accepted_d;
			finished_q      <= finished_d;
			if (judged) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (judged) begin
			out_q <= res;
		end
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("session end cleared");

	a_no_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !judged)
		else $error("result produced after session end");

	a_accept_acks: assert property (@(posedge clk) disable iff (!arst_n)
		(judged && good) |-> (res.ack_valid && res.ack_value == head_entry.ack))
		else $error("accepted packet without its ack");

endmodule

@@ rtl/alternating_bit_receiver_adler32.sv @@
// ----------------------------------------------------------------------------
// alternating_bit_receiver_adler32
// Receive side of an alternating-bit transfer with Adler-32 payload check.
// ----------------------------------------------------------------------------
// Takes one request per cycle, sustained, as long as the result stream keeps
// up: the back end updates both Adler sums and judges a packet combinationally
// from the queue head, so that update sets the rate. A judged request (last
// byte or receive error) is written into the four-entry queue and then into
// the result register, which drives m_tvalid. While the result side stalls,
// the queue still takes up to four more requests. Payload bytes and requests
// arriving after the session has ended give no result.
module alternating_bit_receiver_adler32 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic                              cfg_addr,
	input  logic [15:0]                       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// data_byte[7:0], packet_seq[8], packet_ack[9], packet_checksum[41:10]
	input  logic [abra_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tlast,  // last_byte
	input  logic                              s_tuser,  // req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// ack_valid[0], ack_value[1], status[4:2], packets_received[20:5],
	// session_done[21]
	output logic [abra_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic             q_full, q_push, q_pop, head_valid;
	abra_pkg::entry_t push_entry, head_entry;

	abra_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	abra_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	abra_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_addr   (abra_pkg::cfg_idx_t'(cfg_addr)),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
